// ----- src/assert_macros.svh -----
// assertion macros shared by the bridge modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ARPR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("arpr assertion failed");
// expression must never be true outside reset
`define ARPR_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("arpr forbidden condition seen");
`else
`define ARPR_ASSERT(lbl, clk, rstn, prop)
`define ARPR_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- src/arpr_pkg.sv -----
package arpr_pkg;

	// ethertypes
	localparam logic [15:0] ET_ARP  = 16'h0806;
	localparam logic [15:0] ET_IPV6 = 16'h86DD;
	localparam logic [15:0] ET_IPV4 = 16'h0800;

	// guest frame layout
	localparam int unsigned POS_W = 6;
	localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
	localparam logic [POS_W-1:0] POS_ET_HI    = 6'd12;
	localparam logic [POS_W-1:0] POS_ET_LO    = 6'd13;
	localparam logic [POS_W-1:0] POS_PAYLOAD  = 6'd14;
	localparam logic [POS_W-1:0] POS_ARP_LAST = 6'd41;

	// back end expansion indices
	localparam logic [POS_W-1:0] HDR_LAST_IDX = 6'd14;
	localparam logic [POS_W-1:0] ARP_LAST_IDX = 6'd41;

	// configuration register indices and reset values
	localparam logic [1:0] CFG_GUEST_ADDR = 2'd0;
	localparam logic [1:0] CFG_GW_ADDR    = 2'd1;
	localparam logic [1:0] CFG_HOST_IP    = 2'd2;
	localparam logic [47:0] GUEST_ADDR_RST = 48'h0;
	localparam logic [47:0] GW_ADDR_RST    = 48'h525400ABCDEF;
	localparam logic [31:0] HOST_IP_RST    = 32'hC0A86401;

	// command kinds passed from front to back
	localparam logic [1:0] CMD_HOST_BYTE  = 2'd0;
	localparam logic [1:0] CMD_GUEST_BYTE = 2'd1;
	localparam logic [1:0] CMD_GUEST_HDR  = 2'd2;
	localparam logic [1:0] CMD_ARP_REPLY  = 2'd3;

	typedef struct packed {
		logic       direction;
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       to_guest;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [47:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [47:0] guest_addr;
		logic [47:0] gw_addr;
		logic [31:0] host_ip;
	} cfg_regs_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic        last;
		logic        ipv6;
		logic [47:0] peer_mac;
		logic [31:0] peer_ip;
	} cmd_t;

	// byte of a mac address, most significant first
	function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] sel);
		logic [7:0] r;
		case (sel)
			3'd0:    r = mac[47:40];
			3'd1:    r = mac[39:32];
			3'd2:    r = mac[31:24];
			3'd3:    r = mac[23:16];
			3'd4:    r = mac[15:8];
			default: r = mac[7:0];
		endcase
		return r;
	endfunction

	// byte of an ipv4 address, most significant first
	function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] sel);
		logic [7:0] r;
		case (sel)
			2'd0:    r = ip[31:24];
			2'd1:    r = ip[23:16];
			2'd2:    r = ip[15:8];
			default: r = ip[7:0];
		endcase
		return r;
	endfunction

	// fixed middle of an arp reply: ethertype, htype, ptype, hlen, plen, opcode
	function automatic logic [7:0] arp_fixed_byte(input logic [3:0] sel);
		logic [7:0] r;
		case (sel)
			4'd0:    r = 8'h08;
			4'd1:    r = 8'h06;
			4'd2:    r = 8'h00;
			4'd3:    r = 8'h01;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h00;
			4'd6:    r = 8'h06;
			4'd7:    r = 8'h04;
			4'd8:    r = 8'h00;
			4'd9:    r = 8'h02;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- src/arpr_ifs.sv -----
// input byte channel
interface arpr_in_if;
	logic               valid;
	logic               ready;
	arpr_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// output byte channel
interface arpr_out_if;
	logic                valid;
	logic                ready;
	arpr_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// configuration write channel
interface arpr_cfg_if;
	logic              valid;
	logic              ready;
	arpr_pkg::cfg_wr_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/ethernet_to_ip_bridge_arp_responder_core.sv -----
// Ethernet to raw IP bridge with ARP responder.
// in_ch carries one byte per item with a direction bit: guest Ethernet bytes
// (direction 0) or host raw IP bytes (direction 1), last on the final byte.
// out_ch carries one byte per item with to_guest and out_last.
// cfg_ch writes the guest MAC (index 0), the gateway MAC (1) and host_ip (2);
// other indices are taken and ignored. cfg_ch is always ready.
// The first result passes through the command queue and the output register
// before out_ch.valid rises.
// Throughput: one input byte per cycle when each byte makes at most one
// output byte and out_ch is not stalled. The output port emits one byte per
// cycle while out_ch.ready is high, so a packet's first host byte expands
// to 15 bytes (14 header bytes plus the byte) and an ARP reply to 42 bytes;
// the command queue between the classifier and the byte generator (QUEUE_DEPTH
// entries) absorbs the input while these expand; in_ch.ready drops when full.
// Reset clears the frame position, captured fields, packet state and queue,
// and loads the register reset values; no clearing pass is needed.
// When the receiver stalls, the output register holds its item, the queue
// fills and then the input is held off; nothing is lost.
module ethernet_to_ip_bridge_arp_responder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	arpr_in_if.sink    in_ch,
	arpr_out_if.source out_ch,
	arpr_cfg_if.sink   cfg_ch
);

	arpr_pkg::cfg_regs_t cfg_q;
	logic                in_accept;
	logic                q_push;
	logic                q_full;
	logic                q_pop;
	logic                q_valid;
	arpr_pkg::cmd_t      push_cmd;
	arpr_pkg::cmd_t      head_cmd;

	// configuration registers
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.guest_addr <= arpr_pkg::GUEST_ADDR_RST;
			cfg_q.gw_addr    <= arpr_pkg::GW_ADDR_RST;
			cfg_q.host_ip    <= arpr_pkg::HOST_IP_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				arpr_pkg::CFG_GUEST_ADDR: cfg_q.guest_addr <= cfg_ch.data.wdata;
				arpr_pkg::CFG_GW_ADDR:    cfg_q.gw_addr    <= cfg_ch.data.wdata;
				arpr_pkg::CFG_HOST_IP:    cfg_q.host_ip    <= cfg_ch.data.wdata[31:0];
				default: ;
			endcase
		end
	end

	// input side
	assign in_ch.ready = !q_full;
	assign in_accept   = in_ch.valid && !q_full;

	arpr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.item    (in_ch.data),
		.host_ip (cfg_q.host_ip),
		.push    (q_push),
		.cmd     (push_cmd)
	);

	arpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (head_cmd)
	);

	arpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.pop       (q_pop),
		.out_valid (out_ch.valid),
		.out_item  (out_ch.data),
		.out_ready (out_ch.ready)
	);

endmodule

// ----- src/arpr_queue.sv -----
`include "assert_macros.svh"

module arpr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  arpr_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output arpr_pkg::cmd_t head_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	arpr_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ARPR_ASSERT(a_q_count_bound, clk, arst_n, count_q <= CNT_FULL)
	`ARPR_ASSERT_NEVER(a_q_overflow, clk, arst_n, push && full && !pop)
	`ARPR_ASSERT_NEVER(a_q_underflow, clk, arst_n, pop && !head_valid)

endmodule

// ----- src/arpr_front.sv -----
module arpr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  arpr_pkg::in_item_t item,
	input  logic [31:0]        host_ip,
	output logic               push,
	output arpr_pkg::cmd_t     cmd
);

	logic [arpr_pkg::POS_W-1:0] pos_q;
	logic [15:0] ethertype_q;
	logic [15:0] opcode_q;
	logic [47:0] peer_mac_q;
	logic [31:0] peer_ip_q;
	logic [31:0] target_ip_q;
	logic        rx_in_packet_q;

	logic [15:0] ethertype_n;
	logic [15:0] opcode_n;
	logic [47:0] peer_mac_n;
	logic [31:0] peer_ip_n;
	logic [31:0] target_ip_n;
	logic        ipv4_fwd;
	logic        arp_reply;
	logic [7:0]  b;

	assign b = item.data_byte;

	// capture of header and arp fields by byte position
	always_comb begin
		ethertype_n = ethertype_q;
		opcode_n    = opcode_q;
		peer_mac_n  = peer_mac_q;
		peer_ip_n   = peer_ip_q;
		target_ip_n = target_ip_q;
		if (pos_q == arpr_pkg::POS_ET_HI) begin
			ethertype_n = {b, ethertype_q[7:0]};
		end else if (pos_q == arpr_pkg::POS_ET_LO) begin
			ethertype_n = {ethertype_q[15:8], b};
		end else if (pos_q inside {[6'd20:6'd21]}) begin
			opcode_n = {opcode_q[7:0], b};
		end else if (pos_q inside {[6'd22:6'd27]}) begin
			peer_mac_n = {peer_mac_q[39:0], b};
		end else if (pos_q inside {[6'd28:6'd31]}) begin
			peer_ip_n = {peer_ip_q[23:0], b};
		end else if (pos_q inside {[6'd38:6'd41]}) begin
			target_ip_n = {target_ip_q[23:0], b};
		end
	end

	// classification of guest bytes
	assign ipv4_fwd  = (pos_q >= arpr_pkg::POS_PAYLOAD) && (ethertype_n == arpr_pkg::ET_IPV4);
	assign arp_reply = item.last && (pos_q >= arpr_pkg::POS_ARP_LAST)
		&& (ethertype_n == arpr_pkg::ET_ARP) && (opcode_n == 16'd1)
		&& (target_ip_n == host_ip);

	// command to the back end
	always_comb begin
		cmd.data_byte = b;
		cmd.last      = item.last;
		cmd.ipv6      = (b[7:4] == 4'd6);
		cmd.peer_mac  = peer_mac_n;
		cmd.peer_ip   = peer_ip_n;
		if (item.direction) begin
			cmd.kind = rx_in_packet_q ? arpr_pkg::CMD_GUEST_BYTE : arpr_pkg::CMD_GUEST_HDR;
		end else if (arp_reply) begin
			cmd.kind = arpr_pkg::CMD_ARP_REPLY;
		end else begin
			cmd.kind = arpr_pkg::CMD_HOST_BYTE;
		end
	end

	assign push = accept && (item.direction || ipv4_fwd || arp_reply);

	// guest position and captured fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			ethertype_q    <= '0;
			opcode_q       <= '0;
			peer_mac_q     <= '0;
			peer_ip_q      <= '0;
			target_ip_q    <= '0;
			rx_in_packet_q <= 1'b0;
		end else if (accept) begin
			if (item.direction) begin
				rx_in_packet_q <= !item.last;
			end else begin
				ethertype_q <= ethertype_n;
				opcode_q    <= opcode_n;
				peer_mac_q  <= peer_mac_n;
				peer_ip_q   <= peer_ip_n;
				target_ip_q <= target_ip_n;
				if (item.last) begin
					pos_q <= '0;
				end else if (pos_q != arpr_pkg::POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- src/arpr_back.sv -----
`include "assert_macros.svh"

module arpr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  arpr_pkg::cfg_regs_t cfg,
	input  logic                cmd_valid,
	input  arpr_pkg::cmd_t      cmd,
	output logic                pop,
	output logic                out_valid,
	output arpr_pkg::out_item_t out_item,
	input  logic                out_ready
);

	logic [arpr_pkg::POS_W-1:0] idx_q;
	logic                       out_valid_q;
	arpr_pkg::out_item_t        out_item_q;

	logic [arpr_pkg::POS_W-1:0] last_idx;
	logic                       at_end;
	logic                       load;
	arpr_pkg::out_item_t        gen;
	logic [arpr_pkg::POS_W-1:0] rel6;
	logic [arpr_pkg::POS_W-1:0] rel12;
	logic [arpr_pkg::POS_W-1:0] rel22;
	logic [arpr_pkg::POS_W-1:0] rel28;
	logic [arpr_pkg::POS_W-1:0] rel32;
	logic [arpr_pkg::POS_W-1:0] rel38;

	// index of the final byte of the current command
	always_comb begin
		case (cmd.kind)
			arpr_pkg::CMD_GUEST_HDR: last_idx = arpr_pkg::HDR_LAST_IDX;
			arpr_pkg::CMD_ARP_REPLY: last_idx = arpr_pkg::ARP_LAST_IDX;
			default:                 last_idx = '0;
		endcase
	end

	assign at_end = (idx_q == last_idx);
	assign load   = cmd_valid && (!out_valid_q || out_ready);
	assign pop    = load && at_end;

	assign rel6  = idx_q - 6'd6;
	assign rel12 = idx_q - 6'd12;
	assign rel22 = idx_q - 6'd22;
	assign rel28 = idx_q - 6'd28;
	assign rel32 = idx_q - 6'd32;
	assign rel38 = idx_q - 6'd38;

	// byte generator
	always_comb begin
		gen.out_byte = cmd.data_byte;
		gen.to_guest = 1'b1;
		gen.out_last = 1'b0;
		case (cmd.kind)
			arpr_pkg::CMD_HOST_BYTE: begin
				gen.to_guest = 1'b0;
				gen.out_last = cmd.last;
			end
			arpr_pkg::CMD_GUEST_BYTE: begin
				gen.out_last = cmd.last;
			end
			arpr_pkg::CMD_GUEST_HDR: begin
				if (idx_q < 6'd6) begin
					gen.out_byte = arpr_pkg::mac_byte(cfg.guest_addr, idx_q[2:0]);
				end else if (idx_q < 6'd12) begin
					gen.out_byte = arpr_pkg::mac_byte(cfg.gw_addr, rel6[2:0]);
				end else if (idx_q == 6'd12) begin
					gen.out_byte = cmd.ipv6 ? arpr_pkg::ET_IPV6[15:8] : arpr_pkg::ET_IPV4[15:8];
				end else if (idx_q == 6'd13) begin
					gen.out_byte = cmd.ipv6 ? arpr_pkg::ET_IPV6[7:0] : arpr_pkg::ET_IPV4[7:0];
				end else begin
					gen.out_last = cmd.last;
				end
			end
			default: begin
				// arp reply frame
				if (idx_q < 6'd6) begin
					gen.out_byte = arpr_pkg::mac_byte(cmd.peer_mac, idx_q[2:0]);
				end else if (idx_q < 6'd12) begin
					gen.out_byte = arpr_pkg::mac_byte(cfg.gw_addr, rel6[2:0]);
				end else if (idx_q < 6'd22) begin
					gen.out_byte = arpr_pkg::arp_fixed_byte(rel12[3:0]);
				end else if (idx_q < 6'd28) begin
					gen.out_byte = arpr_pkg::mac_byte(cfg.gw_addr, rel22[2:0]);
				end else if (idx_q < 6'd32) begin
					gen.out_byte = arpr_pkg::ip_byte(cfg.host_ip, rel28[1:0]);
				end else if (idx_q < 6'd38) begin
					gen.out_byte = arpr_pkg::mac_byte(cmd.peer_mac, rel32[2:0]);
				end else begin
					gen.out_byte = arpr_pkg::ip_byte(cmd.peer_ip, rel38[1:0]);
					gen.out_last = at_end;
				end
			end
		endcase
	end

	// expansion counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_end ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= gen;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`ARPR_ASSERT(a_idx_idle, clk, arst_n, !cmd_valid |-> idx_q == '0)
	`ARPR_ASSERT(a_idx_range, clk, arst_n, idx_q <= arpr_pkg::ARP_LAST_IDX)
	`ARPR_ASSERT(a_single_byte_cmd, clk, arst_n, (cmd_valid && last_idx == '0) |-> idx_q == '0)

endmodule

// ----- test/ethernet_to_ip_bridge_arp_responder_core_tb.sv -----
module ethernet_to_ip_bridge_arp_responder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// direction codes of an input item
	localparam logic DIR_GUEST = 1'b0;
	localparam logic DIR_HOST  = 1'b1;

	// register index the block takes and ignores
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// arp field positions within a guest frame
	localparam logic [arpr_pkg::POS_W-1:0] ARP_OP_POS   = 6'd20;
	localparam logic [arpr_pkg::POS_W-1:0] ARP_SMAC_POS = 6'd22;
	localparam logic [arpr_pkg::POS_W-1:0] ARP_SIP_POS  = 6'd28;
	localparam logic [arpr_pkg::POS_W-1:0] ARP_TIP_POS  = 6'd38;
	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
	localparam logic [15:0] ARP_HTYPE_ETH  = 16'd1;

	// ethertype, htype, ptype, hlen, plen and opcode of a reply
	localparam logic [79:0] ARP_REPLY_FIXED =
		{arpr_pkg::ET_ARP, ARP_HTYPE_ETH, arpr_pkg::ET_IPV4, 8'd6, 8'd4, ARP_OP_REPLY};

	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_CYCLES    = 300000;

	typedef enum int {
		FR_IPV4, FR_IPV6, FR_OTHER, FR_ARP_HIT, FR_ARP_MISS, FR_ARP_SHORT, FR_RUNT, FR_LONG
	} frame_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	arpr_in_if  in_if();
	arpr_out_if out_if();
	arpr_cfg_if cfg_if();

	// locally held drive values
	logic                in_valid = 1'b0;
	arpr_pkg::in_item_t  in_item = '0;
	logic                out_ready = 1'b0;
	logic                cfg_valid = 1'b0;
	arpr_pkg::cfg_wr_t   cfg_wr = '0;

	assign in_if.valid  = in_valid;
	assign in_if.data   = in_item;
	assign out_if.ready = out_ready;
	assign cfg_if.valid = cfg_valid;
	assign cfg_if.data  = cfg_wr;

	ethernet_to_ip_bridge_arp_responder_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_if),
		.out_ch(out_if),
		.cfg_ch(cfg_if)
	);

	arpr_pkg::in_item_t  pending_in_bytes[$];
	arpr_pkg::out_item_t expected_out_bytes[$];
	logic [7:0]          guest_frame[$];
	logic [7:0]          host_packet[$];

	int   queued_in_count = 0;
	int   taken_in_count = 0;
	int   fail_count = 0;
	int   cycle_count = 0;
	int   send_idle_pct = 22;
	int   recv_idle_pct = 53;
	int   hold_asks = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	logic in_took = 1'b0;

	// register copies
	logic [47:0] reg_guest_addr = arpr_pkg::GUEST_ADDR_RST;
	logic [47:0] reg_gw_addr    = arpr_pkg::GW_ADDR_RST;
	logic [31:0] reg_host_ip    = arpr_pkg::HOST_IP_RST;

	// bridge state
	logic [arpr_pkg::POS_W-1:0] frame_pos = '0;
	logic [15:0]                frame_etype = '0;
	logic [15:0]                arp_op = '0;
	logic [47:0]                arp_smac = '0;
	logic [31:0]                arp_sip = '0;
	logic [31:0]                arp_tip = '0;
	logic                       host_pkt_open = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void push_out(logic [7:0] b, logic guest, logic lst);
		arpr_pkg::out_item_t o;
		o.out_byte = b;
		o.to_guest = guest;
		o.out_last = lst;
		expected_out_bytes = {expected_out_bytes, o};
	endfunction

	function automatic void push_mac(logic [47:0] mac);
		for (int k = 5; k >= 0; k--)
			push_out(mac[8*k +: 8], 1'b1, 1'b0);
	endfunction

	function automatic void push_ip(logic [31:0] ip, logic lst);
		for (int k = 3; k >= 0; k--)
			push_out(ip[8*k +: 8], 1'b1, lst && k == 0);
	endfunction

	// expected output items for one accepted input item
	function automatic void bridge_byte(arpr_pkg::in_item_t it);
		logic [arpr_pkg::POS_W-1:0] pos;
		logic [7:0]                 b;
		logic [15:0]                et;
		b = it.data_byte;
		if (it.direction == DIR_GUEST) begin
			pos = frame_pos;
			// capture header and arp fields by position
			if (pos == arpr_pkg::POS_ET_HI) begin
				frame_etype[15:8] = b;
			end else if (pos == arpr_pkg::POS_ET_LO) begin
				frame_etype[7:0] = b;
			end else if (pos >= ARP_OP_POS && pos < ARP_OP_POS + 2) begin
				arp_op = {arp_op[7:0], b};
			end else if (pos >= ARP_SMAC_POS && pos < ARP_SMAC_POS + 6) begin
				arp_smac = {arp_smac[39:0], b};
			end else if (pos >= ARP_SIP_POS && pos < ARP_SIP_POS + 4) begin
				arp_sip = {arp_sip[23:0], b};
			end else if (pos >= ARP_TIP_POS && pos < ARP_TIP_POS + 4) begin
				arp_tip = {arp_tip[23:0], b};
			end
			// ipv4 payload goes to the host
			if (pos >= arpr_pkg::POS_PAYLOAD && frame_etype == arpr_pkg::ET_IPV4)
				push_out(b, 1'b0, it.last);
			// arp reply on the final byte of a matching request
			if (it.last && pos >= arpr_pkg::POS_ARP_LAST && frame_etype == arpr_pkg::ET_ARP &&
					arp_op == ARP_OP_REQUEST && arp_tip == reg_host_ip) begin
				push_mac(arp_smac);
				push_mac(reg_gw_addr);
				for (int k = 9; k >= 0; k--)
					push_out(ARP_REPLY_FIXED[8*k +: 8], 1'b1, 1'b0);
				push_mac(reg_gw_addr);
				push_ip(reg_host_ip, 1'b0);
				push_mac(arp_smac);
				push_ip(arp_sip, 1'b1);
			end
			if (it.last)
				frame_pos = '0;
			else if (pos != arpr_pkg::POS_MAX)
				frame_pos = pos + 1'b1;
		end else begin
			// ethernet header ahead of the first byte of a host packet
			if (!host_pkt_open) begin
				et = (b[7:4] == 4'd6) ? arpr_pkg::ET_IPV6 : arpr_pkg::ET_IPV4;
				push_mac(reg_guest_addr);
				push_mac(reg_gw_addr);
				push_out(et[15:8], 1'b1, 1'b0);
				push_out(et[7:0], 1'b1, 1'b0);
			end
			push_out(b, 1'b1, it.last);
			host_pkt_open = !it.last;
		end
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (pending_in_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= pending_in_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_served != hold_asks) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// register writes, input prediction and output checks
	always @(posedge clk) begin : sample_proc
		arpr_pkg::out_item_t want;
		in_took <= arst_n && in_if.valid && in_if.ready;
		if (arst_n && cfg_if.valid && cfg_if.ready) begin
			case (cfg_if.data.index)
				arpr_pkg::CFG_GUEST_ADDR: reg_guest_addr = cfg_if.data.wdata;
				arpr_pkg::CFG_GW_ADDR:    reg_gw_addr = cfg_if.data.wdata;
				arpr_pkg::CFG_HOST_IP:    reg_host_ip = cfg_if.data.wdata[31:0];
				default: ;
			endcase
		end
		if (arst_n && in_if.valid && in_if.ready) begin
			bridge_byte(in_if.data);
			taken_in_count++;
		end
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_out_bytes.size() == 0) begin
				$error("unexpected output item: out_byte %h to_guest %b out_last %b",
					out_if.data.out_byte, out_if.data.to_guest, out_if.data.out_last);
				fail_count++;
			end else begin
				want = expected_out_bytes.pop_front();
				if (out_if.data.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, out_if.data.out_byte);
					fail_count++;
				end
				if (out_if.data.to_guest !== want.to_guest) begin
					$error("to_guest: expected %b, got %b", want.to_guest, out_if.data.to_guest);
					fail_count++;
				end
				if (out_if.data.out_last !== want.out_last) begin
					$error("out_last: expected %b, got %b", want.out_last, out_if.data.out_last);
					fail_count++;
				end
			end
		end
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_in(logic dir, logic [7:0] b, logic lst);
		arpr_pkg::in_item_t it;
		it.direction = dir;
		it.data_byte = b;
		it.last = lst;
		pending_in_bytes = {pending_in_bytes, it};
		queued_in_count++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_wr <= '{index: idx, wdata: value};
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// block drained: every item taken, nothing expected, queue settled
	task automatic wait_idle();
		do @(negedge clk);
		while (taken_in_count != queued_in_count || expected_out_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void set_frame_field(int at, logic [31:0] value, int nbytes);
		for (int i = 0; i < nbytes; i++)
			if (at + i < guest_frame.size())
				guest_frame[at + i] = value[8*(nbytes-1-i) +: 8];
	endfunction

	function automatic void build_guest_frame(frame_kind_t k);
		int          len;
		logic [15:0] etype;
		logic [15:0] opcode;
		logic [31:0] target;
		etype = arpr_pkg::ET_ARP;
		opcode = ARP_OP_REQUEST;
		target = reg_host_ip;
		case (k)
			FR_IPV4: begin
				len = $urandom_range(14, 24);
				etype = arpr_pkg::ET_IPV4;
			end
			FR_IPV6: begin
				len = $urandom_range(14, 24);
				etype = arpr_pkg::ET_IPV6;
			end
			FR_OTHER: begin
				len = $urandom_range(14, 24);
				etype = 16'($urandom);
			end
			FR_ARP_HIT: len = $urandom_range(42, 46);
			FR_ARP_MISS: begin
				len = $urandom_range(42, 46);
				if ($urandom_range(1) == 0)
					opcode = ARP_OP_REQUEST ^ 16'($urandom_range(1, 65535));
				else
					target = reg_host_ip ^ (32'd1 << $urandom_range(31));
			end
			FR_ARP_SHORT: len = $urandom_range(28, 41);
			FR_RUNT: begin
				len = $urandom_range(1, 13);
				etype = 16'($urandom);
			end
			default: begin
				len = $urandom_range(64, 70);
				etype = ($urandom_range(1) == 0) ? arpr_pkg::ET_IPV4 : arpr_pkg::ET_ARP;
			end
		endcase
		guest_frame.delete();
		repeat (len) guest_frame = {guest_frame, 8'($urandom)};
		set_frame_field(arpr_pkg::POS_ET_HI, {16'd0, etype}, 2);
		if (etype == arpr_pkg::ET_ARP) begin
			set_frame_field(ARP_OP_POS, {16'd0, opcode}, 2);
			set_frame_field(ARP_TIP_POS, target, 4);
		end
	endfunction

	function automatic void build_host_packet(int len);
		host_packet.delete();
		repeat (len) host_packet = {host_packet, 8'($urandom)};
		if ($urandom_range(1) == 0)
			host_packet[0][7:4] = 4'd6;
	endfunction

	function automatic frame_kind_t pick_frame_kind();
		int r;
		r = $urandom_range(99);
		if (r < 25) return FR_IPV4;
		if (r < 50) return FR_ARP_HIT;
		if (r < 58) return FR_IPV6;
		if (r < 65) return FR_OTHER;
		if (r < 77) return FR_ARP_MISS;
		if (r < 85) return FR_ARP_SHORT;
		if (r < 95) return FR_RUNT;
		return FR_LONG;
	endfunction

	// mix guest frame and host packet bytes, each kept in order
	task automatic queue_interleaved();
		logic [7:0] b;
		logic       lst;
		while (guest_frame.size() != 0 || host_packet.size() != 0) begin
			if (host_packet.size() == 0 ||
					(guest_frame.size() != 0 && $urandom_range(1) == 0)) begin
				b = guest_frame.pop_front();
				lst = (guest_frame.size() == 0);
				queue_in(DIR_GUEST, b, lst);
			end else begin
				b = host_packet.pop_front();
				lst = (host_packet.size() == 0);
				queue_in(DIR_HOST, b, lst);
			end
		end
	endtask

	task automatic random_phase(int n);
		int target;
		int r;
		target = queued_in_count + n;
		while (queued_in_count < target) begin
			r = $urandom_range(9);
			guest_frame.delete();
			host_packet.delete();
			if (r < 8)
				build_guest_frame(pick_frame_kind());
			if (r >= 5)
				build_host_packet($urandom_range(1, 8));
			queue_interleaved();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single-byte ipv6 packet, two-byte ipv4 packet
		queue_in(DIR_HOST, 8'h6F, 1'b1);
		queue_in(DIR_HOST, 8'h00, 1'b0);
		queue_in(DIR_HOST, 8'hFF, 1'b1);
		// ipv4 frame with an empty payload
		for (int i = 0; i < 14; i++) begin
			if (i == arpr_pkg::POS_ET_HI)
				queue_in(DIR_GUEST, arpr_pkg::ET_IPV4[15:8], 1'b0);
			else if (i == arpr_pkg::POS_ET_LO)
				queue_in(DIR_GUEST, arpr_pkg::ET_IPV4[7:0], 1'b1);
			else
				queue_in(DIR_GUEST, 8'hFF, 1'b0);
		end
		// runt frame, then a one-byte frame inside a host packet
		queue_in(DIR_GUEST, 8'h00, 1'b0);
		queue_in(DIR_GUEST, 8'h00, 1'b0);
		queue_in(DIR_GUEST, 8'h00, 1'b1);
		queue_in(DIR_HOST, 8'h45, 1'b0);
		queue_in(DIR_GUEST, 8'hFF, 1'b1);
		queue_in(DIR_HOST, 8'h00, 1'b1);
		wait_idle();

		// all-ones guest address, zero gateway address, spare index, random upper bits on host_ip
		write_reg(arpr_pkg::CFG_GUEST_ADDR, 48'hFFFF_FFFF_FFFF);
		write_reg(arpr_pkg::CFG_GW_ADDR, 48'h0);
		write_reg(arpr_pkg::CFG_HOST_IP, {16'($urandom), 32'hFFFF_FFFF});
		write_reg(CFG_SPARE, {16'($urandom), 32'($urandom)});
		random_phase(50);
		wait_idle();

		// sender idles more than the receiver, random addresses
		send_idle_pct = 53;
		recv_idle_pct = 22;
		write_reg(arpr_pkg::CFG_GUEST_ADDR, {16'($urandom), 32'($urandom)});
		write_reg(arpr_pkg::CFG_GW_ADDR, {16'($urandom), 32'($urandom)});
		write_reg(arpr_pkg::CFG_HOST_IP, {16'($urandom), 32'($urandom)});
		random_phase(50);
		wait_idle();

		// no idling; long receiver hold-off while input keeps coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(arpr_pkg::CFG_GUEST_ADDR, 48'h0);
		write_reg(arpr_pkg::CFG_GW_ADDR, 48'hFFFF_FFFF_FFFF);
		write_reg(arpr_pkg::CFG_HOST_IP, 48'h0);
		hold_asks = hold_asks + 1;
		build_host_packet(20);
		build_guest_frame(FR_ARP_HIT);
		queue_interleaved();
		random_phase(50);
		wait_idle();

		if (fail_count == 0 && expected_out_bytes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
